[rtl/quoted_field_tokenizer_unit_macros.svh]
// Assertion macros for the tokenizer's port-level checker.
// Depends on nothing; included by the checker file.
`ifndef QUOTED_FIELD_TOKENIZER_UNIT_MACROS_SVH
`define QUOTED_FIELD_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

[rtl/qft_pkg.sv]
// Shared constants for the quoted field tokenizer.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package qft_pkg;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int CHAR_W   = 8;
	localparam int COUNT_W  = 6;
	localparam int PHASE_W  = 3;

	localparam int OUT_NULL_BIT  = 8;
	localparam int OUT_FINAL_BIT = 9;

	localparam int PEND_DEPTH = 63;
	localparam int PEND_AW    = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SEP_SET   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELIMITED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRIM      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARS = 3'd5;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	function automatic logic is_space(input logic [CHAR_W-1:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

endpackage

[rtl/quoted_field_tokenizer_unit.sv]
// Quoted field tokenizer: splits a byte stream into tokens with quoting and trimming.
// Depends on qft_pkg; held-back whitespace lives in a RAM with a registered read port.
`timescale 1ns / 1ps

// Channel   Dir  Payload
// s_axis    in   tdata[7:0] text_byte, tlast end_of_string
// m_axis    out  tdata[7:0] token_char, [8] token_null, [9] final_token;
//                tuser kind, tlast last result of the input transaction
// cfg       in   cfg_en, cfg_index, cfg_data
// An input transaction is taken while the block is idle; each result is then loaded
// as the output register frees, and each flushed whitespace byte first passes a RAM
// read state before its output state. A byte with one result keeps the block busy until that result is loaded.
// Input is taken only while no results of the previous byte remain.
// Reset restores the register defaults and the between-tokens state; the RAM
// needs no clearing.

module quoted_field_tokenizer_unit
	import qft_pkg::*;
#(
	parameter int TOKEN_LIMIT     = 63,
	parameter int SEPARATOR_SLOTS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] text_byte
	input  logic                  s_tlast,   // end_of_string
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] token_char, [8] token_null, [9] final_token
	output logic                  m_tuser,   // kind
	output logic                  m_tlast,   // last
	input  logic                  cfg_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ACT_SLOTS = (SEPARATOR_SLOTS < 4) ? SEPARATOR_SLOTS : 4;
	localparam logic [COUNT_W-1:0] LIMIT_C = COUNT_W'(TOKEN_LIMIT);
	localparam logic [COUNT_W-1:0] PEND_MAX = COUNT_W'(PEND_DEPTH);

	localparam logic [PHASE_W-1:0] PH_START = 3'd0;
	localparam logic [PHASE_W-1:0] PH_UNQ   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_QUO   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_QEND  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_HOLD  = 3'd4;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_END  = 3'd1;
	localparam logic [2:0] ST_FRD  = 3'd2;
	localparam logic [2:0] ST_FOUT = 3'd3;
	localparam logic [2:0] ST_CHAR = 3'd4;

	logic [31:0]        sep_set_q;
	logic [2:0]         sep_cnt_q;
	logic               delim_q;
	logic [CHAR_W-1:0]  quote_q;
	logic               trim_q;
	logic [COUNT_W-1:0] max_chars_q;

	logic [PHASE_W-1:0] phase_q;
	logic [COUNT_W-1:0] kept_q;
	logic [COUNT_W-1:0] pcnt_q;
	logic               seen_q;

	logic [2:0]         state_q;
	logic               job_null_q;
	logic               job_fin_q;
	logic [COUNT_W-1:0] job_cnt_q;
	logic               job_char_q;
	logic [CHAR_W-1:0]  job_byte_q;
	logic [PEND_AW-1:0] fidx_q;

	logic [CHAR_W-1:0]  pend_mem [PEND_DEPTH];
	logic [CHAR_W-1:0]  rd_data_q;

	logic               out_valid_q;
	logic               out_kind_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_null_q;
	logic               out_fin_q;
	logic               out_last_q;

	logic [CHAR_W-1:0]  in_byte;
	logic               eos;
	logic               accept;
	logic               sep_hit;
	logic               quote_hit;
	logic [COUNT_W-1:0] lim;
	logic               do_end;
	logic               take;
	logic [PHASE_W-1:0] nphase;
	logic [COUNT_W-1:0] k0, p0, nk, np;
	logic               s0, ns;
	logic               emit_char;
	logic [COUNT_W-1:0] flush_n;
	logic               wr_en;
	logic               can_load;
	logic               rd_en;
	logic               load;
	logic               ld_kind;
	logic [CHAR_W-1:0]  ld_char;
	logic               ld_null;
	logic               ld_fin;
	logic               ld_last;
	logic [2:0]         state_d;
	logic [PEND_AW-1:0] fidx_inc;

	assign in_byte   = s_tdata[CHAR_W-1:0];
	assign eos       = s_tlast || (in_byte == '0);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign quote_hit = (quote_q != '0) && (in_byte == quote_q);
	assign lim       = (max_chars_q > LIMIT_C) ? LIMIT_C : max_chars_q;
	assign can_load  = !out_valid_q || m_tready;
	assign fidx_inc  = fidx_q + PEND_AW'(1);

	always_comb begin
		sep_hit = 1'b0;
		for (int i = 0; i < ACT_SLOTS; i++) begin
			if ((3'(i) < sep_cnt_q) && (sep_set_q[8*i +: 8] == in_byte)) begin
				sep_hit = 1'b1;
			end
		end
	end

	always_comb begin
		do_end = 1'b0;
		take   = 1'b0;
		nphase = phase_q;
		if (eos) begin
			do_end = 1'b1;
			nphase = PH_START;
		end else begin
			case (phase_q)
				PH_UNQ: begin
					if (sep_hit) begin
						if (delim_q) begin
							do_end = 1'b1;
							nphase = PH_START;
						end else begin
							nphase = PH_HOLD;
						end
					end else begin
						take = 1'b1;
					end
				end
				PH_QUO: begin
					if (in_byte == quote_q) begin
						nphase = PH_QEND;
					end else begin
						take = 1'b1;
					end
				end
				PH_QEND, PH_HOLD: begin
					priority if ((phase_q == PH_QEND) && (in_byte == quote_q)) begin
						take   = 1'b1;
						nphase = PH_QUO;
					end else if (sep_hit) begin
						if (delim_q) begin
							do_end = 1'b1;
							nphase = PH_START;
						end else begin
							nphase = PH_HOLD;
						end
					end else begin
						do_end = 1'b1;
						if (quote_hit) begin
							nphase = PH_QUO;
						end else begin
							nphase = PH_UNQ;
							take   = 1'b1;
						end
					end
				end
				default: begin
					if (sep_hit) begin
						do_end = delim_q;
						nphase = PH_START;
					end else if (quote_hit) begin
						nphase = PH_QUO;
					end else begin
						nphase = PH_UNQ;
						take   = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		k0 = do_end ? '0 : kept_q;
		p0 = do_end ? '0 : pcnt_q;
		s0 = do_end ? 1'b0 : seen_q;
		nk = k0;
		np = p0;
		ns = s0;
		emit_char = 1'b0;
		flush_n   = '0;
		wr_en     = 1'b0;
		if (take && (k0 < lim)) begin
			nk = k0 + COUNT_W'(1);
			if (!trim_q) begin
				emit_char = 1'b1;
			end else if (is_space(in_byte)) begin
				if (s0 && (p0 < PEND_MAX)) begin
					wr_en = 1'b1;
					np    = p0 + COUNT_W'(1);
				end
			end else begin
				flush_n   = p0;
				np        = '0;
				emit_char = 1'b1;
				ns        = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		load    = 1'b0;
		ld_kind = KIND_CHAR;
		ld_char = '0;
		ld_null = 1'b0;
		ld_fin  = 1'b0;
		ld_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (do_end) begin
						state_d = ST_END;
					end else if (flush_n != '0) begin
						state_d = ST_FRD;
					end else if (emit_char) begin
						state_d = ST_CHAR;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_END: begin
				if (can_load) begin
					load    = 1'b1;
					ld_kind = KIND_END;
					ld_null = job_null_q;
					ld_fin  = job_fin_q;
					ld_last = (job_cnt_q == '0) && !job_char_q;
					priority if (job_cnt_q != '0) begin
						state_d = ST_FRD;
					end else if (job_char_q) begin
						state_d = ST_CHAR;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FRD: begin
				rd_en   = 1'b1;
				state_d = ST_FOUT;
			end
			ST_FOUT: begin
				if (can_load) begin
					load    = 1'b1;
					ld_char = rd_data_q;
					ld_last = (COUNT_W'(fidx_inc) == job_cnt_q) && !job_char_q;
					priority if (COUNT_W'(fidx_inc) != job_cnt_q) begin
						state_d = ST_FRD;
					end else if (job_char_q) begin
						state_d = ST_CHAR;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CHAR: begin
				if (can_load) begin
					load    = 1'b1;
					ld_char = job_byte_q;
					ld_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_set_q   <= '0;
			sep_cnt_q   <= '0;
			delim_q     <= 1'b0;
			quote_q     <= '0;
			trim_q      <= 1'b0;
			max_chars_q <= COUNT_W'(63);
		end else if (cfg_en) begin
			case (cfg_index)
				REG_SEP_SET:   sep_set_q   <= cfg_data;
				REG_SEP_COUNT: sep_cnt_q   <= cfg_data[2:0];
				REG_DELIMITED: delim_q     <= cfg_data[0];
				REG_QUOTE:     quote_q     <= cfg_data[CHAR_W-1:0];
				REG_TRIM:      trim_q      <= cfg_data[0];
				REG_MAX_CHARS: max_chars_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			kept_q      <= '0;
			pcnt_q      <= '0;
			seen_q      <= 1'b0;
			state_q     <= ST_IDLE;
			fidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				phase_q <= nphase;
				kept_q  <= nk;
				pcnt_q  <= np;
				seen_q  <= ns;
				fidx_q  <= '0;
			end else if ((state_q == ST_FOUT) && can_load) begin
				fidx_q <= fidx_inc;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_null_q <= trim_q && !seen_q;
			job_fin_q  <= eos;
			job_cnt_q  <= flush_n;
			job_char_q <= emit_char;
			job_byte_q <= in_byte;
		end
		if (load) begin
			out_kind_q <= ld_kind;
			out_char_q <= ld_char;
			out_null_q <= ld_null;
			out_fin_q  <= ld_fin;
			out_last_q <= ld_last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			pend_mem[p0[PEND_AW-1:0]] <= in_byte;
		end
		if (rd_en) begin
			rd_data_q <= pend_mem[fidx_q];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(OUT_DATA_W - CHAR_W - 2)'(0), out_fin_q, out_null_q, out_char_q};

endmodule

[rtl/qft_checker.sv]
// Port-level checker for the quoted field tokenizer, bound to the top level.
// Depends on qft_pkg and quoted_field_tokenizer_unit_macros.svh.
`timescale 1ns / 1ps
`include "quoted_field_tokenizer_unit_macros.svh"

module qft_checker
	import qft_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser,
	input logic                  m_tlast,
	input logic                  cfg_en,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// A stalled result transaction keeps its contents.
	`QFT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// Character results never carry end-marker flags.
	`QFT_ASSERT_IMPL(a_char_flags, clk, arst_n, m_tvalid && (m_tuser == KIND_CHAR), !m_tdata[OUT_NULL_BIT] && !m_tdata[OUT_FINAL_BIT])

	// End markers carry no character.
	`QFT_ASSERT_IMPL(a_end_char_zero, clk, arst_n, m_tvalid && (m_tuser == KIND_END), m_tdata[CHAR_W-1:0] == '0)

	// The final token of a string closes the results of its byte.
	`QFT_ASSERT_IMPL(a_final_last, clk, arst_n, m_tvalid && (m_tuser == KIND_END) && m_tdata[OUT_FINAL_BIT], m_tlast)

endmodule

bind quoted_field_tokenizer_unit qft_checker u_qft_checker (.*);

[dv/quoted_field_tokenizer_unit_checker.sv]
`timescale 1ns / 1ps
// Checker for the quoted field tokenizer: follows both stream channels and the config port.
// It predicts the token stream from the accepted bytes and compares each result transaction.
// Depends on qft_pkg for widths, register indexes and result kinds.

module quoted_field_tokenizer_unit_checker
	import qft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  m_tuser,
	input  logic                  m_tlast,
	input  logic                  cfg_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    results_due
);

	localparam int KEEP_CAP  = 63;
	localparam int SLOT_CAP  = 4;
	localparam int STEP_CAP  = 64;
	localparam int HELD_CAP  = 63;

	typedef enum logic [PHASE_W-1:0] {
		SCAN_START,
		SCAN_PLAIN,
		SCAN_QUOTED,
		SCAN_QUOTE_SEEN,
		SCAN_HOLD
	} scan_e;

	typedef struct packed {
		logic              kind;
		logic [CHAR_W-1:0] ch;
		logic              is_null;
		logic              is_final;
		logic              last;
	} token_item_t;

	logic [31:0]        sep_bytes;
	logic [2:0]         sep_used;
	logic               split_each;
	logic [CHAR_W-1:0]  quote_byte;
	logic               trim_on;
	logic [COUNT_W-1:0] char_limit;

	scan_e             scan;
	int                kept_chars;
	logic [CHAR_W-1:0] held_ws[$];
	logic              saw_text;

	token_item_t step_items[$];
	token_item_t expected_items[$];

	function automatic logic is_separator(input logic [CHAR_W-1:0] b);
		int n;
		n = (sep_used > SLOT_CAP) ? SLOT_CAP : sep_used;
		for (int i = 0; i < n; i++)
			if (sep_bytes[i*8 +: 8] == b)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic is_blank(input logic [CHAR_W-1:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

	function automatic void emit(input logic kind, input logic [CHAR_W-1:0] ch,
			input logic nul, input logic fin);
		if (step_items.size() < STEP_CAP)
			step_items.push_back('{kind, ch, nul, fin, 1'b0});
	endfunction

	function automatic void close_token(input logic fin);
		emit(KIND_END, 8'h00, trim_on && !saw_text, fin);
		kept_chars = 0;
		held_ws.delete();
		saw_text = 1'b0;
	endfunction

	// Held whitespace is only released by a kept non-space character.
	function automatic void keep_char(input logic [CHAR_W-1:0] b);
		int lim;
		lim = (char_limit > KEEP_CAP) ? KEEP_CAP : char_limit;
		if (kept_chars >= lim)
			return;
		kept_chars++;
		if (!trim_on) begin
			emit(KIND_CHAR, b, 1'b0, 1'b0);
		end else if (is_blank(b)) begin
			if (saw_text && held_ws.size() < HELD_CAP)
				held_ws.push_back(b);
		end else begin
			foreach (held_ws[i])
				emit(KIND_CHAR, held_ws[i], 1'b0, 1'b0);
			held_ws.delete();
			emit(KIND_CHAR, b, 1'b0, 1'b0);
			saw_text = 1'b1;
		end
	endfunction

	function automatic void begin_token(input logic [CHAR_W-1:0] b);
		if (is_separator(b)) begin
			if (split_each)
				close_token(1'b0);
		end else if (quote_byte != 8'h00 && b == quote_byte) begin
			scan = SCAN_QUOTED;
		end else begin
			scan = SCAN_PLAIN;
			keep_char(b);
		end
	endfunction

	// The end marker of a finished token waits here until the next byte shows
	// whether another token follows.
	function automatic void after_token(input logic [CHAR_W-1:0] b);
		if (is_separator(b)) begin
			if (split_each) begin
				close_token(1'b0);
				scan = SCAN_START;
			end
		end else begin
			close_token(1'b0);
			scan = SCAN_START;
			begin_token(b);
		end
	endfunction

	function automatic void predict_byte(input logic [CHAR_W-1:0] b, input logic eos);
		step_items.delete();
		if (eos || b == 8'h00) begin
			close_token(1'b1);
			scan = SCAN_START;
		end else begin
			case (scan)
				SCAN_START: begin_token(b);
				SCAN_PLAIN: begin
					if (is_separator(b)) begin
						if (split_each) begin
							close_token(1'b0);
							scan = SCAN_START;
						end else begin
							scan = SCAN_HOLD;
						end
					end else begin
						keep_char(b);
					end
				end
				SCAN_QUOTED: begin
					if (b == quote_byte)
						scan = SCAN_QUOTE_SEEN;
					else
						keep_char(b);
				end
				SCAN_QUOTE_SEEN: begin
					if (b == quote_byte) begin
						keep_char(b);
						scan = SCAN_QUOTED;
					end else begin
						scan = SCAN_HOLD;
						after_token(b);
					end
				end
				SCAN_HOLD: after_token(b);
				default: begin
					scan = SCAN_START;
					begin_token(b);
				end
			endcase
		end
		if (step_items.size() > 0)
			step_items[step_items.size()-1].last = 1'b1;
		foreach (step_items[i])
			expected_items.push_back(step_items[i]);
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SEP_SET:   sep_bytes  = data;
			REG_SEP_COUNT: sep_used   = data[2:0];
			REG_DELIMITED: split_each = data[0];
			REG_QUOTE:     quote_byte = data[CHAR_W-1:0];
			REG_TRIM:      trim_on    = data[0];
			REG_MAX_CHARS: char_limit = data[COUNT_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			fail_count++;
		end
	endfunction

	function automatic void check_result();
		token_item_t want;
		if (expected_items.size() == 0) begin
			$display("%0t: result with nothing expected, actual tuser %0b tdata %h tlast %0b",
				$time, m_tuser, m_tdata, m_tlast);
			fail_count++;
		end else begin
			want = expected_items.pop_front();
			compare_field("kind", 32'(want.kind), 32'(m_tuser));
			compare_field("token_char", 32'(want.ch), 32'(m_tdata[CHAR_W-1:0]));
			compare_field("token_null", 32'(want.is_null), 32'(m_tdata[OUT_NULL_BIT]));
			compare_field("final_token", 32'(want.is_final), 32'(m_tdata[OUT_FINAL_BIT]));
			compare_field("last", 32'(want.last), 32'(m_tlast));
			compare_field("tdata padding", 32'(0),
				32'(m_tdata[OUT_DATA_W-1:OUT_FINAL_BIT+1]));
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			sep_bytes   = '0;
			sep_used    = '0;
			split_each  = 1'b0;
			quote_byte  = 8'h00;
			trim_on     = 1'b0;
			char_limit  = 6'd63;
			scan        = SCAN_START;
			kept_chars  = 0;
			saw_text    = 1'b0;
			held_ws.delete();
			expected_items.delete();
			fail_count  = 0;
			results_due = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_en)
				apply_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				predict_byte(s_tdata[CHAR_W-1:0], s_tlast);
			results_due = expected_items.size();
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench top for quoted_field_tokenizer_unit: drives byte strings and register writes.
// Checking is done by quoted_field_tokenizer_unit_checker; depends on qft_pkg.

module tb;
	import qft_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int IDLE_PCT        = 18;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int PHASE_BYTES     = 8;
	localparam int SETTLE_CYCLES   = 16;

	// Each entry is {end_of_string, text_byte}.
	localparam logic [8:0] OPENING_SEQ [23] = '{
		9'h02C, 9'h020, 9'h061, 9'h020, 9'h020, 9'h062, 9'h020, 9'h03B,
		9'h022, 9'h070, 9'h02C, 9'h022, 9'h022, 9'h071, 9'h022,
		9'h07A, 9'h022, 9'h079, 9'h0FF, 9'h022, 9'h075, 9'h141, 9'h000
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int results_due;
	int cycle_count = 0;
	int bytes_sent = 0;
	bit idle_on = 1'b1;
	bit hold_off_req = 1'b0;
	bit hold_done = 1'b0;

	logic [31:0]       cur_set;
	logic [2:0]        cur_count;
	logic [CHAR_W-1:0] cur_quote;

	always #10 clk = ~clk;

	quoted_field_tokenizer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	quoted_field_tokenizer_unit_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_en      (cfg_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[quoted_field_tokenizer_unit] ERROR");
			$finish;
		end
	end

	// The receiver stalls at random and once holds off long enough to back up the input.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			m_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
	endtask

	task automatic configure(input logic [31:0] sep_set, input logic [2:0] sep_count,
			input logic delim, input logic [CHAR_W-1:0] quote, input logic trim,
			input logic [COUNT_W-1:0] max_chars);
		write_reg(REG_SEP_SET, sep_set);
		write_reg(REG_SEP_COUNT, CFG_DATA_W'(sep_count));
		write_reg(REG_DELIMITED, CFG_DATA_W'(delim));
		write_reg(REG_QUOTE, CFG_DATA_W'(quote));
		write_reg(REG_TRIM, CFG_DATA_W'(trim));
		write_reg(REG_MAX_CHARS, CFG_DATA_W'(max_chars));
		@(negedge clk);
		cfg_en    <= 1'b0;
		cur_set   = sep_set;
		cur_count = sep_count;
		cur_quote = quote;
	endtask

	task automatic send_byte(input logic [CHAR_W-1:0] b, input logic eos);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	function automatic logic [CHAR_W-1:0] pick_sep();
		int slot;
		if (cur_count == 0)
			return 8'h2C;
		slot = $urandom_range((cur_count > 4) ? 3 : cur_count - 1);
		return cur_set[slot*8 +: 8];
	endfunction

	function automatic logic [CHAR_W-1:0] pick_text();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return 8'h61 + 8'($urandom_range(25));
			5, 6: return ($urandom_range(5) == 5) ? 8'h20 : 8'h09 + 8'($urandom_range(4));
			7: return (cur_quote != 8'h00) ? cur_quote : 8'h78;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic send_seps();
		repeat ($urandom_range(1, 3)) send_byte(pick_sep(), 1'b0);
	endtask

	// Mostly short tokens; a few run past the longest character limit.
	task automatic send_token();
		int len;
		bit quoted;
		len = ($urandom_range(99) < 8) ? $urandom_range(55, 70) : $urandom_range(0, 8);
		quoted = (cur_quote != 8'h00) && ($urandom_range(99) < 35);
		if (quoted)
			send_byte(cur_quote, 1'b0);
		repeat (len) begin
			if (quoted && $urandom_range(99) < 10) begin
				send_byte(cur_quote, 1'b0);
				send_byte(cur_quote, 1'b0);
			end else if (quoted && $urandom_range(99) < 15) begin
				send_byte(pick_sep(), 1'b0);
			end else begin
				send_byte(pick_text(), 1'b0);
			end
		end
		if (quoted && $urandom_range(99) < 85)
			send_byte(cur_quote, 1'b0);
	endtask

	task automatic send_random_string();
		int n_tok;
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(1, 255)), 1'b0);
		end else begin
			n_tok = $urandom_range(0, 4);
			if ($urandom_range(1))
				send_seps();
			for (int t = 0; t < n_tok; t++) begin
				send_token();
				if (t < n_tok - 1 || $urandom_range(3) == 0)
					send_seps();
			end
		end
		if ($urandom_range(1))
			send_byte(8'($urandom), 1'b1);
		else
			send_byte(8'h00, 1'b0);
	endtask

	// An open quoted token with held whitespace carries over into the next settings.
	task automatic random_phase(input int target, input bit leave_open);
		int first;
		first = bytes_sent;
		while (bytes_sent - first < target)
			send_random_string();
		if (leave_open && cur_quote != 8'h00) begin
			send_byte(cur_quote, 1'b0);
			send_byte(8'h61, 1'b0);
			send_byte(8'h20, 1'b0);
			send_byte(8'h20, 1'b0);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_en    = 1'b0;
		cfg_index = REG_SEP_SET;
		cfg_data  = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		configure(32'h00FF_3B2C, 3'd3, 1'b1, 8'h22, 1'b1, 6'd63);
		foreach (OPENING_SEQ[i])
			send_byte(OPENING_SEQ[i][7:0], OPENING_SEQ[i][8]);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: configure(32'h2009_3B2C, 3'd4, 1'b0, 8'h27, 1'b1, 6'd63);
				1: configure(32'hFF27_3B2C, 3'd4, 1'b1, 8'h27, 1'b0, 6'd1);
				2: configure(32'h0000_0000, 3'd0, 1'b0, 8'h00, 1'b0, 6'd63);
				3: configure(32'hFFFF_FFFF, 3'd4, 1'b1, 8'hFF, 1'b1, 6'd63);
				4: configure($urandom, 3'($urandom_range(4)), 1'($urandom_range(1)),
					8'($urandom_range(255)), 1'($urandom_range(1)),
					6'($urandom_range(1, 63)));
				default: configure(32'h0000_7C2C, 3'd2, 1'b1, 8'h22, 1'b1, 6'd5);
			endcase
			idle_on = (p != 1);
			hold_off_req = (p == 2);
			random_phase(PHASE_BYTES, p == 0 || p == 4);
			drain();
		end

		if (fail_count == 0 && results_due == 0)
			$display("[quoted_field_tokenizer_unit] OK");
		else
			$display("[quoted_field_tokenizer_unit] ERROR");
		$finish;
	end

endmodule
